@@ sv/ece_pkg.sv @@
package ece_pkg;

  // Fixed point format and table geometry.
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 256;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int HALF        = 1 << (FRAC_BITS - 1);

  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam longint unsigned LN2_Q30    = 64'd744261118;
  localparam longint unsigned Q30_ONE    = 64'd1 << 30;

  // Curve families.
  typedef enum logic [2:0] {
    FAM_ELASTIC,
    FAM_EXPO,
    FAM_QUAD,
    FAM_COS,
    FAM_SINE
  } fam_t;

  // Treatment after the curve: none, lower half or upper half of an in-out form.
  typedef enum logic [1:0] {
    POST_NONE,
    POST_LOW,
    POST_HIGH
  } post_t;

  // Form of a curve kind: in, out or in-out.
  typedef enum logic [1:0] {
    FORM_IN,
    FORM_OUT,
    FORM_INOUT
  } form_t;

  typedef struct packed {
    logic  lin;
    fam_t  fam;
    form_t form;
  } kind_dec_t;

  typedef logic [17:0] tab_t [0:TABLE_DEPTH];

  // Curve kind register decode.
  function automatic kind_dec_t decode_kind(input logic [3:0] kind);
    kind_dec_t d;
    d.lin  = 1'b0;
    d.fam  = FAM_ELASTIC;
    d.form = FORM_IN;
    case (kind)
      4'd1:  begin d.fam = FAM_ELASTIC; d.form = FORM_IN;    end
      4'd2:  begin d.fam = FAM_ELASTIC; d.form = FORM_OUT;   end
      4'd3:  begin d.fam = FAM_ELASTIC; d.form = FORM_INOUT; end
      4'd4:  begin d.fam = FAM_EXPO;    d.form = FORM_IN;    end
      4'd5:  begin d.fam = FAM_EXPO;    d.form = FORM_OUT;   end
      4'd6:  begin d.fam = FAM_EXPO;    d.form = FORM_INOUT; end
      4'd7:  begin d.fam = FAM_QUAD;    d.form = FORM_IN;    end
      4'd8:  begin d.fam = FAM_QUAD;    d.form = FORM_OUT;   end
      4'd9:  begin d.fam = FAM_QUAD;    d.form = FORM_INOUT; end
      4'd10: begin d.fam = FAM_COS;     d.form = FORM_IN;    end
      4'd11: begin d.fam = FAM_COS;     d.form = FORM_OUT;   end
      4'd12: begin d.fam = FAM_COS;     d.form = FORM_INOUT; end
      4'd13: begin d.fam = FAM_SINE;    d.form = FORM_IN;    end
      4'd14: begin d.fam = FAM_SINE;    d.form = FORM_OUT;   end
      4'd15: begin d.fam = FAM_SINE;    d.form = FORM_INOUT; end
      default: d.lin = 1'b1;
    endcase
    return d;
  endfunction

  // Unsigned product of two Q16 values, rounded half up.
  function automatic logic [16:0] mulq(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] prod;
    prod = 34'(a) * 34'(b) + 34'(HALF);
    return prod[32:16];
  endfunction

  function automatic logic [17:0] q30_to_frac(input longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
    return r[17:0];
  endfunction

  // Unsigned quotient by restoring long division, used by the table builders.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter wave sine table, built from a truncated series at elaboration.
  function automatic tab_t build_sine();
    tab_t t;
    longint unsigned th, th2, term;
    longint sum;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      th   = (HALFPI_Q30 * longint'(i) + TABLE_DEPTH / 2) / TABLE_DEPTH;
      th2  = (th * th) >> 30;
      term = th;
      sum  = longint'(th);
      for (int k = 1; k <= 10; k++) begin
        term = udiv((term * th2) >> 30, longint'((2 * k) * (2 * k + 1)));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      t[i] = q30_to_frac(longint'(sum));
    end
    return t;
  endfunction

  // Fraction table of 2^(i/depth), built from the exponential series.
  function automatic tab_t build_pow();
    tab_t t;
    longint unsigned u, et, es;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      u  = (LN2_Q30 * longint'(i) + TABLE_DEPTH / 2) / TABLE_DEPTH;
      et = Q30_ONE;
      es = Q30_ONE;
      for (int k = 1; k <= 20; k++) begin
        et = udiv((et * u) >> 30, longint'(k));
        es = es + et;
      end
      t[i] = q30_to_frac(es);
    end
    return t;
  endfunction

endpackage

@@ sv/easing_curve_evaluator.sv @@
// Channel   Ports                          Direction  Beat
// input     start, busy, progress          in         start high and busy low
// config    cfg_valid, cfg_ready, cfg_data in         cfg_valid and cfg_ready high
// result    done, eased_value              out        done high for one cycle
//
// Eight register stages lie between an input beat and its result.
// One item is taken every cycle; the multiplier chain of the elastic curve and
// the two stage table interpolation set the depth.
// Synchronous reset clears the valid bits and sets the curve kind to linear;
// busy is high only while reset is held.
// The receiver cannot stall, so the pipeline never holds and busy never rises
// in operation.
module easing_curve_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [16:0]        progress,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output logic               done,
  output logic signed [18:0] eased_value
);

  localparam logic [16:0]        ONE17 = 17'(ece_pkg::ONE);
  localparam logic signed [19:0] ONE_S = 20'(ece_pkg::ONE);
  localparam logic signed [19:0] TWO_S = 20'(2 * ece_pkg::ONE);

  typedef struct packed {
    logic               lin;
    ece_pkg::fam_t      fam;
    logic               out_form;
    ece_pkg::post_t     post;
    logic [16:0]        x;
    logic [16:0]        z;
    logic [16:0]        s2;
    logic [16:0]        s4;
    logic [16:0]        s8;
    logic [16:0]        zz;
    logic [19:0]        n;
    logic [16:0]        lf;
    logic               neg;
    logic [3:0]         k;
    logic [17:0]        lv;
    logic [17:0]        pw;
    logic signed [19:0] em;
    logic signed [19:0] c;
  } pipe_t;

  logic [3:0] curve_kind;
  logic       accept;
  logic [7:1] vld;
  pipe_t      p1, p2, p3, p4, p5, p6, p7;
  pipe_t      p1_next, p2_next, p3_next, p4_next, p6_next, p7_next;
  logic [17:0] table_value;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      curve_kind <= cfg_data;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[6:1], accept};
      done <= vld[7];
    end
  end

  // Stage 1: saturate, fold in-out forms and pick the curve argument.
  always_comb begin
    ece_pkg::kind_dec_t dec;
    logic [16:0] xs, t;
    logic [17:0] two_x;
    logic        rev, low;
    dec   = ece_pkg::decode_kind(curve_kind);
    xs    = (progress > ONE17) ? ONE17 : progress;
    two_x = {xs, 1'b0};
    low   = xs < 17'(ece_pkg::HALF);
    p1_next = '0;
    p1_next.lin      = dec.lin;
    p1_next.fam      = dec.fam;
    p1_next.out_form = dec.form == ece_pkg::FORM_OUT;
    p1_next.x        = xs;
    t = xs;
    p1_next.post = ece_pkg::POST_NONE;
    if (!dec.lin && dec.form == ece_pkg::FORM_INOUT) begin
      t = low ? two_x[16:0] : 17'(18'(2 * ece_pkg::ONE) - two_x);
      p1_next.post = low ? ece_pkg::POST_LOW : ece_pkg::POST_HIGH;
    end
    case (dec.fam)
      ece_pkg::FAM_QUAD, ece_pkg::FAM_SINE: rev = p1_next.out_form;
      default: rev = !p1_next.out_form;
    endcase
    p1_next.z = rev ? (ONE17 - t) : t;
  end

  // Stage 2: first squares and the exponent argument.
  always_comb begin
    p2_next    = p1;
    p2_next.s2 = ece_pkg::mulq(ONE17 - p1.z, ONE17 - p1.z);
    p2_next.zz = ece_pkg::mulq(p1.z, p1.z);
    p2_next.n  = 20'(p1.z) * 20'd10;
  end

  // Stage 3: fourth power and the table argument for each family.
  always_comb begin
    logic [19:0] ph;
    p3_next    = p2;
    p3_next.s4 = ece_pkg::mulq(p2.s2, p2.s2);
    ph         = 20'(p2.zz) * 20'd12;
    p3_next.lf = p2.z;
    case (p2.fam)
      ece_pkg::FAM_ELASTIC: begin
        p3_next.lf  = ph[16] ? (ONE17 - {1'b0, ph[15:0]}) : {1'b0, ph[15:0]};
        p3_next.neg = ph[17];
      end
      ece_pkg::FAM_EXPO: begin
        p3_next.k  = p2.n[19:16];
        p3_next.lf = ONE17 - {1'b0, p2.n[15:0]};
      end
      default: p3_next.lf = p2.z;
    endcase
  end

  // Stage 4: eighth power of the elastic decay term.
  always_comb begin
    p4_next    = p3;
    p4_next.s8 = ece_pkg::mulq(p3.s4, p3.s4);
  end

  ece_interp u_interp (
    .clk     (clk),
    .frac    (p3.lf),
    .sel_pow (p3.fam == ece_pkg::FAM_EXPO),
    .value   (table_value)
  );

  // Stage 6: elastic sine term and the power of two shift.
  always_comb begin
    logic [16:0] m;
    logic [18:0] sum;
    p6_next    = p5;
    p6_next.lv = table_value;
    m          = ece_pkg::mulq(table_value[16:0], p5.s2);
    p6_next.em = p5.neg ? -$signed({3'b000, m}) : $signed({3'b000, m});
    sum        = {1'b0, table_value} + (19'd1 << p5.k);
    p6_next.pw = 18'(sum >> (p5.k + 4'd1));
  end

  // Stage 7: curve value and the in or out inversion.
  always_comb begin
    logic signed [19:0] core;
    logic               inv;
    p7_next = p6;
    case (p6.fam)
      ece_pkg::FAM_ELASTIC: begin
        core = ONE_S - $signed({3'b000, p6.s8}) + p6.em;
        inv  = !p6.out_form;
      end
      ece_pkg::FAM_EXPO: begin
        core = $signed({2'b00, p6.pw});
        inv  = p6.out_form;
      end
      ece_pkg::FAM_QUAD: begin
        core = $signed({3'b000, p6.zz});
        inv  = p6.out_form;
      end
      ece_pkg::FAM_COS: begin
        core = $signed({2'b00, p6.lv});
        inv  = !p6.out_form;
      end
      default: begin
        core = $signed({2'b00, p6.lv});
        inv  = 1'b0;
      end
    endcase
    p7_next.c = inv ? (ONE_S - core) : core;
    if (p6.lin) p7_next.c = $signed({3'b000, p6.x});
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    p1 <= p1_next;
    p2 <= p2_next;
    p3 <= p3_next;
    p4 <= p4_next;
    p5 <= p4;
    p6 <= p6_next;
    p7 <= p7_next;
  end

  // Stage 8: in-out halving, saturation and the output register.
  always_ff @(posedge clk) begin
    logic signed [19:0] h, y;
    h = p7.c >>> 1;
    case (p7.post)
      ece_pkg::POST_LOW:  y = h;
      ece_pkg::POST_HIGH: y = ONE_S - h;
      default:            y = p7.c;
    endcase
    if (y > TWO_S) y = TWO_S;
    if (y < -TWO_S) y = -TWO_S;
    eased_value <= y[18:0];
  end

  // Fixed latency from input beat to result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##8 done)
    else $error("result strobe missing eight cycles after input beat");

  // Results stay within the saturation range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (eased_value <= 19'sd131072) && (eased_value >= -19'sd131072))
    else $error("eased value outside saturation range");

  // A configuration beat lands in the curve kind register.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> curve_kind == $past(cfg_data))
    else $error("curve kind not updated by configuration beat");

endmodule

@@ sv/ece_interp.sv @@
// Two stage interpolated table lookup over the sine and power tables.
module ece_interp (
  input  logic        clk,
  input  logic [16:0] frac,
  input  logic        sel_pow,
  output logic [17:0] value
);

  localparam int IW = $clog2(ece_pkg::TABLE_DEPTH);
  localparam int SH = ece_pkg::FRAC_BITS - IW;
  localparam ece_pkg::tab_t SINE_TAB = ece_pkg::build_sine();
  localparam ece_pkg::tab_t POW_TAB  = ece_pkg::build_pow();

  logic          clamp;
  logic [IW-1:0] idx;
  logic [IW:0]   idx_a, idx_b;
  logic [17:0]   a_c, b_c, d_c;
  logic [17:0]   a_q, d_q;
  logic [15:0]   rem_c, rem_q;
  logic [33:0]   prod;

  // Split the fraction into table index and remainder, then read neighbors.
  always_comb begin
    clamp = frac[ece_pkg::FRAC_BITS];
    idx   = frac[ece_pkg::FRAC_BITS-1:SH];
    rem_c = {frac[SH-1:0], {IW{1'b0}}};
    idx_a = clamp ? (IW+1)'(ece_pkg::TABLE_DEPTH) : {1'b0, idx};
    idx_b = {1'b0, idx} + (IW+1)'(1);
    a_c   = sel_pow ? POW_TAB[idx_a] : SINE_TAB[idx_a];
    b_c   = sel_pow ? POW_TAB[idx_b] : SINE_TAB[idx_b];
    d_c   = (!clamp && (b_c > a_c)) ? (b_c - a_c) : 18'd0;
  end

  always_ff @(posedge clk) begin
    a_q   <= a_c;
    d_q   <= d_c;
    rem_q <= rem_c;
  end

  // Linear interpolation, rounded half up.
  assign prod = 34'(d_q) * 34'(rem_q) + 34'(ece_pkg::HALF);

  always_ff @(posedge clk) begin
    value <= a_q + prod[33:16];
  end

endmodule

@@ tb/tb_easing_curve_evaluator.sv @@
`timescale 1ns / 1ps

module tb_easing_curve_evaluator;

  localparam longint QONE  = longint'(1) << ece_pkg::FRAC_BITS;
  localparam longint QHALF = longint'(1) << (ece_pkg::FRAC_BITS - 1);

  // Curve kind codes used by the directed part.
  localparam logic [3:0] KIND_LINEAR     = 4'd0;
  localparam logic [3:0] KIND_EXPO_INOUT = 4'd6;
  localparam logic [3:0] KIND_SINE_INOUT = 4'd15;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  kind;
    logic [16:0] x;
  } stim_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [16:0]        progress;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         cfg_data;
  logic               done;
  logic signed [18:0] eased_value;

  stim_t              stim_q[$];
  logic signed [18:0] eased_q[$];
  longint             sin_rom[0:ece_pkg::TABLE_DEPTH];
  longint             pow_rom[0:ece_pkg::TABLE_DEPTH];
  logic [3:0]         active_kind;
  int                 gap;
  int                 quiet;
  bit                 no_idle;
  int                 n_items;
  int                 n_cfg;
  int                 n_checked;
  int                 n_err;

  easing_curve_evaluator u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .progress   (progress),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .eased_value(eased_value)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Sine quarter wave and 2^t fraction tables from truncated series in Q30.
  function automatic longint q30_round(input longint unsigned v);
    return longint'((v + (64'd1 << (29 - ece_pkg::FRAC_BITS))) >> (30 - ece_pkg::FRAC_BITS));
  endfunction

  task automatic fill_roms();
    longint unsigned th, th2, term, u, et, es;
    longint sum;
    for (int i = 0; i <= ece_pkg::TABLE_DEPTH; i++) begin
      th   = (64'd1686629713 * longint'(i) + ece_pkg::TABLE_DEPTH / 2) / ece_pkg::TABLE_DEPTH;
      th2  = (th * th) >> 30;
      term = th;
      sum  = longint'(th);
      u    = (64'd744261118 * longint'(i) + ece_pkg::TABLE_DEPTH / 2) / ece_pkg::TABLE_DEPTH;
      et   = 64'd1 << 30;
      es   = 64'd1 << 30;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      sin_rom[i] = q30_round(longint'(sum));
      for (int k = 1; k <= 20; k++) begin
        et = ((et * u) >> 30) / longint'(k);
        es = es + et;
      end
      pow_rom[i] = q30_round(es);
    end
  endtask

  // Signed fixed point product, rounded half away from zero.
  function automatic longint rnd_mul(input longint a, input longint b);
    longint ma, mb, m;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m  = (ma * mb + QHALF) >>> ece_pkg::FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Linear interpolation in a table at fraction f, rounding half up.
  function automatic longint tab_lerp(input bit use_pow, input longint f);
    longint pos, idx, rem, a, b, d;
    if (f < 0) f = 0;
    if (f > QONE) f = QONE;
    pos = f * ece_pkg::TABLE_DEPTH;
    idx = pos >>> ece_pkg::FRAC_BITS;
    rem = pos & (QONE - 1);
    if (idx >= ece_pkg::TABLE_DEPTH)
      return use_pow ? pow_rom[ece_pkg::TABLE_DEPTH] : sin_rom[ece_pkg::TABLE_DEPTH];
    a = use_pow ? pow_rom[idx] : sin_rom[idx];
    b = use_pow ? pow_rom[idx + 1] : sin_rom[idx + 1];
    d = b > a ? b - a : 0;
    return a + ((d * rem + QHALF) >>> ece_pkg::FRAC_BITS);
  endfunction

  // Sine of a phase counted in quarter turns.
  function automatic longint sin_qturn(input longint ph);
    longint quad, f, v;
    quad = (ph >>> ece_pkg::FRAC_BITS) & 3;
    f    = ph & (QONE - 1);
    v    = tab_lerp(1'b0, quad[0] ? QONE - f : f);
    return quad[1] ? -v : v;
  endfunction

  // 2^(-n) for n >= 0.
  function automatic longint exp2_neg(input longint n);
    longint k, f, p;
    k = n >>> ece_pkg::FRAC_BITS;
    f = n & (QONE - 1);
    p = tab_lerp(1'b1, QONE - f);
    if (k + 1 >= 63) return 0;
    return (p + (longint'(1) << k)) >>> (k + 1);
  endfunction

  function automatic longint elastic_rise(input longint x);
    longint s, s2, s8;
    s  = QONE - x;
    s2 = rnd_mul(s, s);
    s8 = rnd_mul(rnd_mul(s2, s2), rnd_mul(s2, s2));
    return QONE - s8 + rnd_mul(sin_qturn(12 * rnd_mul(x, x)), s2);
  endfunction

  function automatic longint family_curve(input ece_pkg::fam_t fam, input bit is_out,
                                          input longint x);
    longint r;
    r = QONE - x;
    case (fam)
      ece_pkg::FAM_ELASTIC: return is_out ? elastic_rise(x) : QONE - elastic_rise(r);
      ece_pkg::FAM_EXPO:    return is_out ? QONE - exp2_neg(10 * x) : exp2_neg(10 * r);
      ece_pkg::FAM_QUAD:    return is_out ? QONE - rnd_mul(r, r) : rnd_mul(x, x);
      ece_pkg::FAM_COS:     return is_out ? tab_lerp(1'b0, x) : QONE - tab_lerp(1'b0, r);
      default:              return is_out ? tab_lerp(1'b0, r) : tab_lerp(1'b0, x);
    endcase
  endfunction

  function automatic longint halve_down(input longint y);
    return y >= 0 ? y / 2 : -((-y + 1) / 2);
  endfunction

  // Eased value for one progress beat under a curve kind.
  function automatic logic signed [18:0] ease_predict(input logic [3:0] kind,
                                                     input logic [16:0] px);
    longint         x, y;
    ece_pkg::fam_t  fam;
    ece_pkg::form_t form;
    x = px > QONE ? QONE : longint'(px);
    if (kind == KIND_LINEAR) begin
      y = x;
    end else begin
      fam  = ece_pkg::fam_t'((kind - 1) / 3);
      form = ece_pkg::form_t'((kind - 1) % 3);
      if (form != ece_pkg::FORM_INOUT) y = family_curve(fam, form == ece_pkg::FORM_OUT, x);
      else if (x < QHALF) y = halve_down(family_curve(fam, 1'b0, 2 * x));
      else y = QONE - halve_down(family_curve(fam, 1'b0, 2 * QONE - 2 * x));
    end
    if (y > 2 * QONE) y = 2 * QONE;
    if (y < -2 * QONE) y = -2 * QONE;
    return y[18:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [16:0] pick_progress();
    case ($urandom_range(0, 15))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'd32768;
      3:       return 17'd32767;
      4:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic push_cfg(input logic [3:0] kind);
    stim_t s;
    s.is_cfg = 1'b1;
    s.kind   = kind;
    s.x      = '0;
    stim_q.push_back(s);
  endtask

  task automatic push_beat(input logic [16:0] x);
    stim_t s;
    s.is_cfg = 1'b0;
    s.kind   = '0;
    s.x      = x;
    stim_q.push_back(s);
  endtask

  // Driver: tracks accepted beats, keeps the model kind, and feeds the next item.
  always @(posedge clk) begin
    int g;
    g = gap;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      gap       <= 0;
      quiet     <= 0;
    end else begin
      quiet <= (done || (start && !busy)) ? 0 : quiet + 1;
      if (start && !busy) begin
        eased_q.push_back(ease_predict(active_kind, progress));
        void'(stim_q.pop_front());
        n_items++;
        if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
        g = pick_gap();
      end else if (cfg_valid && cfg_ready) begin
        active_kind = cfg_data;
        void'(stim_q.pop_front());
        n_cfg++;
        g = pick_gap();
      end else if (gap > 0) begin
        g = gap - 1;
      end
      gap <= g;
      if (g > 0 || stim_q.size() == 0) begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (stim_q[0].is_cfg) begin
        // The register changes only once the pipeline has drained.
        start     <= 1'b0;
        cfg_valid <= eased_q.size() == 0 && quiet >= 12;
        cfg_data  <= stim_q[0].kind;
      end else begin
        start     <= 1'b1;
        progress  <= stim_q[0].x;
        cfg_valid <= 1'b0;
      end
    end
  end

  // Monitor: every done beat is checked against the oldest expected value.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (eased_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, eased_value);
        n_err++;
      end else begin
        if (eased_value !== eased_q[0]) begin
          $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                   $time, eased_q[0], eased_value);
          n_err++;
        end
        void'(eased_q.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    logic [3:0] order[16];
    int         j;
    logic [3:0] t;
    start     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    progress  = '0;
    rst       = 1'b1;
    active_kind = KIND_LINEAR;
    no_idle   = 1'b0;
    n_items   = 0;
    n_cfg     = 0;
    n_checked = 0;
    n_err     = 0;
    fill_roms();

    // Directed: field extremes, saturation and the exponential end points.
    push_cfg(KIND_LINEAR);
    push_beat(17'd0);
    push_beat(17'd1);
    push_beat(17'd32767);
    push_beat(17'd32768);
    push_beat(17'd65535);
    push_beat(17'd65536);
    push_beat(17'd65537);
    push_beat(17'd131071);
    push_cfg(KIND_EXPO_INOUT);
    push_beat(17'd0);
    push_beat(17'd32767);
    push_beat(17'd32768);
    push_beat(17'd65536);
    push_cfg(KIND_SINE_INOUT);
    push_beat(17'd0);
    push_beat(17'd65536);
    push_beat(17'd131071);

    // Random: every curve kind in shuffled order, then a few more settings.
    for (int k = 0; k < 16; k++) order[k] = 4'(k);
    for (int k = 15; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < 16; k++) begin
      push_cfg(order[k]);
      repeat (26) push_beat(pick_progress());
    end
    repeat (4) begin
      push_cfg(4'($urandom_range(0, 15)));
      repeat (20) push_beat(pick_progress());
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || eased_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d progress beats over %0d curve kind writes, %0d results checked.",
             n_items, n_cfg, n_checked);
    if (n_err == 0 && eased_q.size() == 0) begin
      $display("easing_curve_evaluator test passed");
    end else begin
      $display("easing_curve_evaluator test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("easing_curve_evaluator test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ece_pkg.sv
sv/ece_interp.sv
sv/easing_curve_evaluator.sv
tb/tb_easing_curve_evaluator.sv
